/* rtl/core/ocg_pkg.sv */
// package for the oled text command generator
// holds action codes, bus byte constants and the 5x8 glyph table; no dependencies
package ocg_pkg;

    localparam int PAGE_COUNT = 8;

    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_PRINT  = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;

    localparam logic       CFG_ADDR = 1'b0;
    localparam logic       CFG_MUX  = 1'b1;

    localparam logic [7:0] ADDR_RESET = 8'h78;
    localparam logic [5:0] MUX_RESET  = 6'h3F;

    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] BLANK_COL    = 8'h00;
    localparam logic [7:0] CMD_MUX      = 8'hA8;
    localparam logic [7:0] CMD_PUMP     = 8'h8D;
    localparam logic [7:0] PUMP_ON      = 8'h14;
    localparam logic [7:0] CMD_SEG_REV  = 8'hA1;
    localparam logic [7:0] CMD_COM_REV  = 8'hC8;
    localparam logic [7:0] CMD_DISP_ON  = 8'hAF;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [3:0] CMD_COL_HIGH = 4'h1;

    localparam logic [7:0] FIRST_GLYPH = 8'd32;
    localparam logic [7:0] LAST_GLYPH  = 8'd95;

    localparam logic [3:0] LAST_INIT   = 4'd8;
    localparam logic [3:0] LAST_PRINT  = 4'd7;
    localparam logic [3:0] LAST_CURSOR = 4'd4;

    typedef logic [39:0] glyph_t;

    localparam glyph_t FONT [64] = '{
        40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h6264081323, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040
    };

    typedef struct packed {
        logic [1:0] action;
        logic       bad;
        logic [6:0] column;
        logic [2:0] page;
    } cmd_t;

endpackage

/* rtl/core/ocg_font_rom.sv */
// glyph memory: 64 glyphs of five 8-bit columns, registered read
// depends on ocg_pkg for the font table
module ocg_font_rom
    import ocg_pkg::*;
(
    input  logic         clk,
    input  logic         rd_en,
    input  logic [5:0]   rd_addr,
    output glyph_t       rd_data
);

    glyph_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= FONT[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/oled_text_command_generator_top.sv */
// top level of the oled text command generator: command register, byte sequencer, output beat
// depends on ocg_pkg and ocg_font_rom
//
// Each command yields one run of bus beats, one beat per cycle when byte_stall is low: init gives
// nine beats, print gives eight, set cursor gives five, and the unused action code is taken with
// no beat. The next command is taken in the same cycle as the last beat of the current run is
// produced, so runs follow each other with no gap. The rate is set by the byte sequencer, which
// forms one beat a cycle, unless stalled, into a single output register; the glyph is read from
// the font memory in the cycle the print command is taken and is ready for its first beat.
module oled_text_command_generator_top
    import ocg_pkg::*;
#(
    parameter int PANEL_PAGES = PAGE_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column,
    input  logic [2:0]  page,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  bus_byte,
    output logic        start_before,
    output logic        stop_after,
    output logic        bad_char,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [2:0] PAGE_LAST = 3'(PANEL_PAGES - 1);

    logic [7:0] addr_reg;
    logic [5:0] mux_reg;
    logic       busy_reg;
    logic [3:0] idx_reg;
    cmd_t       cmd_reg;
    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       stop_reg;
    logic       bad_reg;

    logic       accept;
    logic       advance;
    logic       last;
    logic [3:0] last_idx;
    logic [7:0] byte_next;
    logic       good;
    logic [7:0] glyph_off;
    glyph_t     glyph;
    logic [2:0] glyph_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
            mux_reg  <= MUX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ADDR: addr_reg <= cfg_data;
                CFG_MUX:  mux_reg  <= cfg_data[5:0];
                default:  addr_reg <= addr_reg;
            endcase
        end
    end

    assign good      = (char_code >= FIRST_GLYPH) && (char_code <= LAST_GLYPH);
    assign glyph_off = char_code - FIRST_GLYPH;

    ocg_font_rom u_font
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (glyph_off[5:0]),
        .rd_data (glyph)
    );

    always_comb
    begin
        case (cmd_reg.action)
            ACT_INIT:   last_idx = LAST_INIT;
            ACT_PRINT:  last_idx = LAST_PRINT;
            default:    last_idx = LAST_CURSOR;
        endcase
    end

    assign last      = (idx_reg == last_idx);
    assign advance   = busy_reg && (!byte_valid_reg || !byte_stall);
    assign cmd_stall = busy_reg && !(advance && last);
    assign accept    = cmd_valid && !cmd_stall;
    assign glyph_sel = 3'(idx_reg - 4'd3);

    always_comb
    begin
        byte_next = BLANK_COL;
        if (idx_reg == 4'd0)
        begin
            byte_next = addr_reg;
        end
        else
        begin
            case (cmd_reg.action)
                ACT_INIT:
                begin
                    case (idx_reg)
                        4'd1:    byte_next = CTRL_CMD;
                        4'd2:    byte_next = CMD_MUX;
                        4'd3:    byte_next = {2'b00, mux_reg};
                        4'd4:    byte_next = CMD_PUMP;
                        4'd5:    byte_next = PUMP_ON;
                        4'd6:    byte_next = CMD_SEG_REV;
                        4'd7:    byte_next = CMD_COM_REV;
                        default: byte_next = CMD_DISP_ON;
                    endcase
                end
                ACT_PRINT:
                begin
                    case (idx_reg)
                        4'd1:    byte_next = CTRL_DATA;
                        4'd2:    byte_next = BLANK_COL;
                        default:
                        begin
                            if (cmd_reg.bad)
                            begin
                                byte_next = BLANK_COL;
                            end
                            else
                            begin
                                case (glyph_sel)
                                    3'd0:    byte_next = glyph[39:32];
                                    3'd1:    byte_next = glyph[31:24];
                                    3'd2:    byte_next = glyph[23:16];
                                    3'd3:    byte_next = glyph[15:8];
                                    default: byte_next = glyph[7:0];
                                endcase
                            end
                        end
                    endcase
                end
                default:
                begin
                    case (idx_reg)
                        4'd1:    byte_next = CTRL_CMD;
                        4'd2:    byte_next = CMD_PAGE | {5'd0, cmd_reg.page};
                        4'd3:    byte_next = {4'h0, cmd_reg.column[3:0]};
                        default: byte_next = {CMD_COL_HIGH, 1'b0, cmd_reg.column[6:4]};
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.action <= action;
            cmd_reg.bad    <= !good;
            cmd_reg.column <= column;
            cmd_reg.page   <= (page > PAGE_LAST) ? PAGE_LAST : page;
        end
        if (advance)
        begin
            byte_reg  <= byte_next;
            start_reg <= (idx_reg == 4'd0);
            stop_reg  <= last;
            bad_reg   <= (cmd_reg.action == ACT_PRINT) && cmd_reg.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= 4'd0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                byte_valid_reg <= 1'b1;
            end
            else if (!byte_stall)
            begin
                byte_valid_reg <= 1'b0;
            end

            if (advance && !last)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
            else if (accept)
            begin
                idx_reg  <= 4'd0;
                busy_reg <= (action == ACT_INIT) || (action == ACT_PRINT)
                            || (action == ACT_CURSOR);
            end
            else if (advance)
            begin
                idx_reg  <= 4'd0;
                busy_reg <= 1'b0;
            end
        end
    end

    assign byte_valid   = byte_valid_reg;
    assign bus_byte     = byte_reg;
    assign start_before = start_reg;
    assign stop_after   = stop_reg;
    assign bad_char     = bad_reg;

endmodule

/* sim/tb_top.sv */
// testbench for oled_text_command_generator_top: random and directed display commands,
// with an in-bench prediction of every bus beat compared as it leaves the block
// depends on ocg_pkg and the rtl of the block
module tb_top
    import ocg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PANEL_PAGES  = 8;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [7:0] MODE_CMD   = 8'h00;
    localparam logic [7:0] MODE_DATA  = 8'h40;
    localparam logic [7:0] EMPTY_COL  = 8'h00;
    localparam logic [7:0] PAGE_BASE  = 8'hB0;
    localparam logic [7:0] COL_HI_CMD = 8'h10;
    localparam logic [7:0] GLYPH_LO   = 8'd32;
    localparam logic [7:0] GLYPH_HI   = 8'd95;

    localparam logic [7:0] SETUP_HEAD   = 8'hA8;
    localparam logic [7:0] SETUP_TAIL [5] = '{8'h8D, 8'h14, 8'hA1, 8'hC8, 8'hAF};

    localparam logic [39:0] GLYPHS [64] = '{
        40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h6264081323, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040
    };

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       bad;
    } bus_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] action = '0;
    logic [7:0] char_code = '0;
    logic [6:0] column = '0;
    logic [2:0] page = '0;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       bad_char;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = '0;

    bus_beat_t  bus_run_q [$];
    bus_beat_t  want;
    logic [7:0] addr_shadow;
    logic [5:0] mux_shadow;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_bytes = 1'b0;
    int errors = 0;
    int cycles = 0;
    int beats_checked = 0;
    int bad_beats = 0;
    int cmd_count [4] = '{0, 0, 0, 0};
    int cfg_writes = 0;

    oled_text_command_generator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .action       (action),
        .char_code    (char_code),
        .column       (column),
        .page         (page),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .bus_byte     (bus_byte),
        .start_before (start_before),
        .stop_after   (stop_after),
        .bad_char     (bad_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles, %0d beats still expected", $realtime,
                     cycles, bus_run_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        byte_stall <= hold_bytes || ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void build_bus_run(input logic [1:0] act, input logic [7:0] code,
                                          input logic [6:0] col, input logic [2:0] pg);
        logic [7:0] run [10];
        int         len;
        logic       no_glyph;
        logic [39:0] cols;
        int         pg_sat;
        bus_beat_t  b;
        len = 0;
        no_glyph = 1'b0;
        run[0] = addr_shadow;
        case (act)
            ACT_INIT:
            begin
                run[1] = MODE_CMD;
                run[2] = SETUP_HEAD;
                run[3] = {2'b00, mux_shadow};
                for (int i = 0; i < 5; i++)
                    run[4 + i] = SETUP_TAIL[i];
                len = 9;
            end
            ACT_PRINT:
            begin
                no_glyph = (code < GLYPH_LO) || (code > GLYPH_HI);
                cols = no_glyph ? 40'd0 : GLYPHS[code - GLYPH_LO];
                run[1] = MODE_DATA;
                run[2] = EMPTY_COL;
                for (int i = 0; i < 5; i++)
                    run[3 + i] = cols[39 - 8 * i -: 8];
                len = 8;
            end
            ACT_CURSOR:
            begin
                pg_sat = (pg >= PANEL_PAGES) ? PANEL_PAGES - 1 : pg;
                run[1] = MODE_CMD;
                run[2] = PAGE_BASE | 8'(pg_sat);
                run[3] = {4'h0, col[3:0]};
                run[4] = COL_HI_CMD | {5'b0, col[6:4]};
                len = 5;
            end
            default:
                len = 0;
        endcase
        for (int k = 0; k < len; k++)
        begin
            b.data  = run[k];
            b.first = (k == 0);
            b.last  = (k == len - 1);
            b.bad   = no_glyph;
            bus_run_q.push_back(b);
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (bus_run_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none actual byte %0h", $realtime,
                         bus_byte);
            end
            else
            begin
                want = bus_run_q.pop_front();
                check_field("bus_byte", want.data, bus_byte);
                check_field("start_before", 8'(want.first), 8'(start_before));
                check_field("stop_after", 8'(want.last), 8'(stop_after));
                check_field("bad_char", 8'(want.bad), 8'(bad_char));
                beats_checked++;
                if (want.bad)
                    bad_beats++;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] act, input logic [7:0] code,
                            input logic [6:0] col, input logic [2:0] pg);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        action    <= act;
        char_code <= code;
        column    <= col;
        page      <= pg;
        do
            @(posedge clk);
        while (cmd_stall);
        build_bus_run(act, code, col, pg);
        cmd_count[act]++;
    endtask

    task automatic send_random_cmd();
        logic [1:0] act;
        logic [7:0] code;
        act = ($urandom_range(99) < 8) ? ACT_UNUSED : 2'($urandom_range(2));
        code = ($urandom_range(99) < 70) ? 8'($urandom_range(GLYPH_HI, GLYPH_LO))
                                         : 8'($urandom_range(255));
        send_cmd(act, code, 7'($urandom_range(127)), 3'($urandom_range(7)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (bus_run_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ADDR)
            addr_shadow = value;
        else
            mux_shadow = value[5:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_cmd(ACT_INIT, 8'd0, 7'd0, 3'd0);
        send_cmd(ACT_PRINT, 8'd65, 7'd0, 3'd0);
        send_cmd(ACT_CURSOR, 8'd0, 7'd0, 3'd0);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        logic [7:0] codes [10] = '{8'd32, 8'd33, 8'd48, 8'd95, 8'd31, 8'd96,
                                   8'd0, 8'd255, 8'd127, 8'd128};
        foreach (codes[i])
            send_cmd(ACT_PRINT, codes[i], 7'd0, 3'd0);
        send_cmd(ACT_CURSOR, 8'd0, 7'd0, 3'd0);
        send_cmd(ACT_CURSOR, 8'd255, 7'd127, 3'd7);
        send_cmd(ACT_CURSOR, 8'd0, 7'h5A, 3'd5);
        send_cmd(ACT_CURSOR, 8'd0, 7'h25, 3'd2);
        // unused action with every field bit set, then with all clear
        send_cmd(ACT_UNUSED, 8'hFF, 7'h7F, 3'h7);
        send_cmd(ACT_UNUSED, 8'h00, 7'h00, 3'h0);
        send_cmd(ACT_INIT, 8'hFF, 7'h7F, 3'h7);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        logic [7:0] addrs [4] = '{8'd0, 8'd254, 8'd255, 8'hA5};
        logic [7:0] muxes [3] = '{8'd15, 8'd63, 8'd42};
        foreach (addrs[i])
        begin
            write_reg(CFG_ADDR, addrs[i]);
            send_cmd(ACT_PRINT, 8'd90, 7'd0, 3'd0);
            send_cmd(ACT_CURSOR, 8'd0, 7'd64, 3'd4);
        end
        foreach (muxes[i])
        begin
            write_reg(CFG_MUX, muxes[i]);
            send_cmd(ACT_INIT, 8'd0, 7'd0, 3'd0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(CFG_ADDR, 8'($urandom_range(255)));
        write_reg(CFG_MUX, 8'($urandom_range(63, 15)));
        repeat (n) send_random_cmd();
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_bytes = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_bytes = 1'b0;
            end
        join_none
        repeat (40) send_random_cmd();
        wait_idle();
    endtask

    initial
    begin
        addr_shadow = 8'h78;
        mux_shadow  = 6'h3F;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_config_extremes();
        test_random_traffic(95, 0, 0);
        test_random_traffic(95, 61, 0);
        test_random_traffic(95, 0, 61);
        test_random_traffic(95, 27, 27);
        test_backpressure();
        write_reg(CFG_ADDR, 8'h78);
        write_reg(CFG_MUX, 8'h3F);
        send_cmd(ACT_INIT, 8'd0, 7'd0, 3'd0);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("run covered %0d init, %0d print, %0d cursor and %0d unused commands",
                 cmd_count[ACT_INIT], cmd_count[ACT_PRINT], cmd_count[ACT_CURSOR],
                 cmd_count[ACT_UNUSED]);
        $display("%0d bus beats checked (%0d flagged bad), %0d register writes, %0d cycles",
                 beats_checked, bad_beats, cfg_writes, cycles);
        if (errors == 0 && bus_run_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
